### hw/rtl/sstr_pkg.sv
// Shared types and constants for the servo slot table with ramp.
package sstr_pkg;

  // Field widths fixed by the transaction format
  localparam int unsigned OP_W    = 2;
  localparam int unsigned PIN_W   = 5;
  localparam int unsigned WIDTH_W = 16;

  // Command codes
  localparam logic [OP_W-1:0] OP_SET_PULSE = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_RAMP  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK      = 2'd2;

  // Ramp step loaded into every slot at reset
  localparam logic [WIDTH_W-1:0] STEP_RESET = 16'd2000;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_TICK
  } sstr_state_t;

endpackage

### hw/rtl/sstr_ramp_unit.sv
// Slew-limited ramp unit: moves a width toward its target by at most one step.
module sstr_ramp_unit
  import sstr_pkg::*;
(
  input  logic [WIDTH_W-1:0] target,
  input  logic [WIDTH_W-1:0] current,
  input  logic [WIDTH_W-1:0] step,
  output logic [WIDTH_W-1:0] next_width
);

  logic               up;
  logic [WIDTH_W-1:0] diff;
  logic [WIDTH_W-1:0] stepped;

  // Measure distance to target and take one bounded step
  always_comb begin
    up      = (target >= current);
    diff    = up ? (target - current) : (current - target);
    stepped = up ? (current + step) : (current - step);
    if (step < diff) begin
      next_width = stepped;
    end else begin
      next_width = target;
    end
  end

endmodule

### hw/rtl/servo_slot_table_with_ramp.sv
// Top level of the servo slot table with slew-limited ramp.
//
// A table of SLOTS servo slots, each holding a pin, a target width, the last
// emitted width and a ramp step (2000 after reset, kept across detach). A
// set-pulse or set-ramp transaction walks the table one slot per cycle to
// find the pin (and the lowest free slot), then commits and returns a single
// status result, which waits while out_stall holds the output. A frame tick
// walks the slots one per cycle through the shared ramp unit, stalling on
// out_stall at occupied slots, and emits one result per occupied slot, the
// last one flagged. An unused opcode skips the walk and gives one all-zero
// result with last set. The block takes one transaction at a time; in_stall
// is high until that transaction has finished.
module servo_slot_table_with_ramp
  import sstr_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [PIN_W-1:0]   in_pin_number,
  input  logic [WIDTH_W-1:0] in_amount,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_status_ok,
  output logic               out_slot_active,
  output logic               out_released,
  output logic [PIN_W-1:0]   out_pulse_pin,
  output logic [WIDTH_W-1:0] out_pulse_width,
  output logic               out_last
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

  sstr_state_t state_r, state_nxt;

  // Latched transaction and walk bookkeeping
  logic [OP_W-1:0]    op_r;
  logic [PIN_W-1:0]   pin_r;
  logic [WIDTH_W-1:0] amt_r;
  logic [IW-1:0]      idx_r;
  logic               hit_r;
  logic [IW-1:0]      hit_idx_r;
  logic               free_r;
  logic [IW-1:0]      free_idx_r;

  // Slot table
  logic [SLOTS-1:0]   used_r;
  logic [PIN_W-1:0]   slot_pin_r     [SLOTS];
  logic [WIDTH_W-1:0] slot_target_r  [SLOTS];
  logic [WIDTH_W-1:0] slot_current_r [SLOTS];
  logic [WIDTH_W-1:0] slot_step_r    [SLOTS];

  // Output register
  logic               out_valid_r;
  logic               out_status_ok_r;
  logic               out_slot_active_r;
  logic               out_released_r;
  logic [PIN_W-1:0]   out_pulse_pin_r;
  logic [WIDTH_W-1:0] out_pulse_width_r;
  logic               out_last_r;

  // Control
  logic               in_acc;
  logic               out_free;
  logic               idx_last;
  logic               cur_used;
  logic               pin_match;
  logic               later_used;
  logic               tick_adv;
  logic               tick_emit;
  logic               commit_go;
  logic               commit_ok;
  logic [WIDTH_W-1:0] ramp_next;

  // Share one ramp unit across the slot walk
  sstr_ramp_unit u_ramp (
    .target     (slot_target_r[idx_r]),
    .current    (slot_current_r[idx_r]),
    .step       (slot_step_r[idx_r]),
    .next_width (ramp_next)
  );

  // Look for occupied slots above the current index
  always_comb begin
    later_used = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (used_r[i] && (i > int'(idx_r))) begin
        later_used = 1'b1;
      end
    end
  end

  // Decode control for the current cycle
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    in_acc    = in_valid && !in_stall;
    out_free  = !out_valid_r || !out_stall;
    idx_last  = (idx_r == IDX_LAST);
    cur_used  = used_r[idx_r];
    pin_match = cur_used && (slot_pin_r[idx_r] == pin_r);
    tick_adv  = (state_r == ST_TICK) && (!cur_used || out_free);
    tick_emit = (state_r == ST_TICK) && cur_used && out_free;
    commit_go = (state_r == ST_COMMIT) && out_free;
    unique case (op_r)
      OP_SET_PULSE: commit_ok = hit_r || free_r;
      OP_SET_RAMP:  commit_ok = hit_r;
      default:      commit_ok = 1'b0;
    endcase
  end

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_TICK) begin
            state_nxt = ST_TICK;
          end else if ((in_opcode == OP_SET_PULSE) || (in_opcode == OP_SET_RAMP)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_COMMIT;
          end
        end
      end
      ST_SCAN: begin
        if (idx_last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (tick_adv && idx_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold control state, walk index, used bits and steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_step_r[i] <= STEP_RESET;
      end
    end else begin
      state_r <= state_nxt;

      // Load a new result, or drop the current one once taken
      if (commit_go || tick_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end

      if (in_acc) begin
        idx_r  <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end

      // Scan for the pin and the lowest free slot
      if (state_r == ST_SCAN) begin
        if (pin_match && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (!cur_used && !free_r) begin
          free_r <= 1'b1;
        end
        if (!idx_last) begin
          idx_r <= idx_r + IW'(1);
        end
      end

      // Apply the set command
      if (commit_go) begin
        if ((op_r == OP_SET_PULSE) && !hit_r && free_r) begin
          used_r[free_idx_r] <= 1'b1;
        end
        if ((op_r == OP_SET_RAMP) && hit_r) begin
          slot_step_r[hit_idx_r] <= amt_r;
        end
      end

      // Walk the slots on a frame tick
      if (tick_adv) begin
        if (!idx_last) begin
          idx_r <= idx_r + IW'(1);
        end
      end
      if (tick_emit) begin
        if (slot_target_r[idx_r] == '0) begin
          used_r[idx_r] <= 1'b0;
        end
      end
    end
  end

  // Hold transaction payload, slot contents and result fields
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_opcode;
      pin_r <= in_pin_number;
      amt_r <= in_amount;
    end

    if (state_r == ST_SCAN) begin
      if (pin_match && !hit_r) begin
        hit_idx_r <= idx_r;
      end
      if (!cur_used && !free_r) begin
        free_idx_r <= idx_r;
      end
    end

    if (commit_go) begin
      if (op_r == OP_SET_PULSE) begin
        if (hit_r) begin
          slot_target_r[hit_idx_r] <= amt_r;
        end else if (free_r) begin
          slot_pin_r[free_idx_r]     <= pin_r;
          slot_target_r[free_idx_r]  <= amt_r;
          slot_current_r[free_idx_r] <= amt_r;
        end
      end
      out_status_ok_r   <= commit_ok;
      out_slot_active_r <= 1'b0;
      out_released_r    <= 1'b0;
      out_pulse_pin_r   <= '0;
      out_pulse_width_r <= '0;
      out_last_r        <= 1'b1;
    end

    if (tick_emit) begin
      out_status_ok_r <= 1'b0;
      out_pulse_pin_r <= slot_pin_r[idx_r];
      out_last_r      <= !later_used;
      if (slot_target_r[idx_r] == '0) begin
        out_slot_active_r <= 1'b0;
        out_released_r    <= 1'b1;
        out_pulse_width_r <= '0;
      end else begin
        slot_current_r[idx_r] <= ramp_next;
        out_slot_active_r     <= 1'b1;
        out_released_r        <= 1'b0;
        out_pulse_width_r     <= ramp_next;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status_ok   = out_status_ok_r;
  assign out_slot_active = out_slot_active_r;
  assign out_released    = out_released_r;
  assign out_pulse_pin   = out_pulse_pin_r;
  assign out_pulse_width = out_pulse_width_r;
  assign out_last        = out_last_r;

endmodule
